/* rtl/slab_slot_allocator_core_defines.svh */
// ----------------------------------------------------------------------------
// Slab slot allocator: assertion macros
// Shared property wrappers for the checker of the slab slot allocator.
// ----------------------------------------------------------------------------
`ifndef SLAB_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define SLAB_SLOT_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ssa_pkg.sv */
// ----------------------------------------------------------------------------
// Slab slot allocator package
// Types, codes and fixed widths shared by the allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ssa_pkg;

  // fixed field widths
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned SIZE_W      = 13;
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 32;

  // configuration reset values
  localparam logic [ADDR_W-1:0] BASE_RESET = '0;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd16;

  // request kinds
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_BAD_ADDR     = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ADDRESS = 1'b0,
    REG_SLOT_SIZE    = 1'b1
  } cfg_reg_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_DIV,
    S_CHECK,
    S_EMIT
  } ctrl_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic    load;
    logic    scan_step;
    logic    div_start;
    logic    div_step;
    logic    set_result;
    status_e res_status;
    logic    commit_alloc;
    logic    commit_free;
    logic    out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic op_free;
    logic full;
    logic slot_free;
    logic range_bad;
    logic div_last;
    logic rem_zero;
    logic quo_used;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/ssa_ctrl.sv */
// ----------------------------------------------------------------------------
// Slab slot allocator controller
// Sequences allocate scans and free-address divisions, one request at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module ssa_ctrl
  import ssa_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  req_valid_i,
  output logic req_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (sts_i.op_free) begin
          state_d = sts_i.range_bad ? S_EMIT : S_DIV;
        end else begin
          state_d = sts_i.full ? S_EMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.slot_free) state_d = S_EMIT;
      end
      S_DIV: begin
        if (sts_i.div_last) state_d = S_CHECK;
      end
      S_CHECK: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!sts_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      S_DECODE: begin
        if (sts_i.op_free) begin
          if (sts_i.range_bad) begin
            cmd_o.set_result = 1'b1;
            cmd_o.res_status = ST_BAD_ADDR;
          end else begin
            cmd_o.div_start = 1'b1;
          end
        end else if (sts_i.full) begin
          cmd_o.set_result = 1'b1;
          cmd_o.res_status = ST_FULL;
        end
      end
      S_SCAN: begin
        if (sts_i.slot_free) begin
          cmd_o.commit_alloc = 1'b1;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      S_CHECK: begin
        if (!sts_i.rem_zero) begin
          cmd_o.set_result = 1'b1;
          cmd_o.res_status = ST_BAD_ADDR;
        end else if (!sts_i.quo_used) begin
          cmd_o.set_result = 1'b1;
          cmd_o.res_status = ST_ALREADY_FREE;
        end else begin
          cmd_o.commit_free = 1'b1;
        end
      end
      S_EMIT: begin
        cmd_o.out_load = !sts_i.out_busy;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/ssa_datapath.sv */
// ----------------------------------------------------------------------------
// Slab slot allocator datapath
// Configuration, used-bit map, free count, scan counter, serial divider and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssa_datapath
  import ssa_pkg::*;
#(
  parameter int unsigned SLOTS = 64
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire  [CFG_DATA_W-1:0]       cfg_data_i,
  input  wire                         req_op_i,
  input  wire  [ADDR_W-1:0]           req_addr_i,
  input  cmd_t                        cmd_i,
  output sts_t                        sts_o,
  input  wire                         out_ready_i,
  output logic                        out_valid_o,
  output logic [OUT_TDATA_W-1:0]      out_data_o
);

  localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned STEP_W = (IDX_W > 1) ? $clog2(IDX_W) : 1;
  localparam int unsigned SPAN_W = SIZE_W + IDX_W;
  localparam int unsigned PAD_N  = 1 << IDX_W;
  localparam int unsigned PAD_W  = OUT_TDATA_W - STATUS_W - ADDR_W - CNT_W;

  localparam logic [SPAN_W-1:0] SLOTS_SPAN = SPAN_W'(SLOTS);
  localparam logic [CNT_W-1:0]  SLOTS_CNT  = CNT_W'(SLOTS);
  localparam logic [IDX_W:0]    SLOTS_IDX  = (IDX_W + 1)'(SLOTS);
  localparam logic [STEP_W-1:0] STEP_TOP   = STEP_W'(IDX_W - 1);

  // configuration
  logic [ADDR_W-1:0] base_q;
  logic [SIZE_W-1:0] size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
      size_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BASE_ADDRESS: base_q <= cfg_data_i[ADDR_W-1:0];
        REG_SLOT_SIZE:    size_q <= cfg_data_i[SIZE_W-1:0];
        default:          base_q <= base_q;
      endcase
    end
  end

  // captured request
  logic              op_q;
  logic [ADDR_W-1:0] off_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= req_op_i;
      off_q <= req_addr_i - base_q;
    end
  end

  // used map, padded with used entries past the last slot
  logic [SLOTS-1:0] used_q;
  logic [PAD_N-1:0] used_pad;
  logic [PAD_N-1:0] used_set;
  logic [PAD_N-1:0] used_clr;
  logic [CNT_W-1:0] count_q;
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] quo_q;

  assign used_pad = ~PAD_N'(~used_q);
  assign used_set = used_pad | (PAD_N'(1) << idx_q);
  assign used_clr = used_pad & ~(PAD_N'(1) << quo_q);

  // used bits and free count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      count_q <= SLOTS_CNT;
    end else if (cmd_i.commit_alloc) begin
      used_q  <= used_set[SLOTS-1:0];
      count_q <= count_q - CNT_W'(1);
    end else if (cmd_i.commit_free) begin
      used_q  <= used_clr[SLOTS-1:0];
      count_q <= count_q + CNT_W'(1);
    end
  end

  // lowest-free scan counter
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q <= '0;
    end else if (cmd_i.scan_step) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  // slab span and range check
  logic [SPAN_W-1:0] span;
  logic              range_bad;

  assign span      = SPAN_W'(size_q) * SLOTS_SPAN;
  assign range_bad = (size_q == '0) || (off_q >= ADDR_W'(span));

  // restoring divider, one quotient bit per cycle
  logic [SPAN_W-1:0] rem_q;
  logic [STEP_W-1:0] step_q;
  logic [SPAN_W-1:0] dvs;
  logic              dvs_ge;
  logic [IDX_W:0]    quo_sh;

  assign dvs    = SPAN_W'(size_q) << step_q;
  assign dvs_ge = rem_q >= dvs;
  assign quo_sh = {quo_q, dvs_ge};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q  <= off_q[SPAN_W-1:0];
      quo_q  <= '0;
      step_q <= STEP_TOP;
    end else if (cmd_i.div_step) begin
      rem_q  <= dvs_ge ? (rem_q - dvs) : rem_q;
      quo_q  <= quo_sh[IDX_W-1:0];
      step_q <= step_q - STEP_W'(1);
    end
  end

  // granted address of the scanned slot
  logic [SPAN_W-1:0] slot_off;
  logic [ADDR_W-1:0] granted;

  assign slot_off = SPAN_W'(size_q) * SPAN_W'(idx_q);
  assign granted  = base_q + ADDR_W'(slot_off);

  // pending result
  status_e           res_status_q;
  logic [ADDR_W-1:0] res_addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_result) begin
      res_status_q <= cmd_i.res_status;
      res_addr_q   <= '0;
    end else if (cmd_i.commit_alloc) begin
      res_status_q <= ST_OK;
      res_addr_q   <= granted;
    end else if (cmd_i.commit_free) begin
      res_status_q <= ST_OK;
      res_addr_q   <= '0;
    end
  end

  // output register
  logic              out_valid_q;
  status_e           out_status_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic [CNT_W-1:0]  out_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_cnt_q    <= count_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{PAD_W{1'b0}}, out_cnt_q, out_addr_q, out_status_q};

  // status to the controller
  always_comb begin
    sts_o           = '0;
    sts_o.op_free   = (op_q == OP_FREE);
    sts_o.full      = (count_q == '0);
    sts_o.slot_free = ({1'b0, idx_q} < SLOTS_IDX) && !used_pad[idx_q];
    sts_o.range_bad = range_bad;
    sts_o.div_last  = (step_q == '0);
    sts_o.rem_zero  = (rem_q == '0);
    sts_o.quo_used  = used_pad[quo_q];
    sts_o.out_busy  = out_valid_q && !out_ready_i;
  end

endmodule

`default_nettype wire

/* rtl/slab_slot_allocator_core.sv */
// ----------------------------------------------------------------------------
// Slab slot allocator core
// Bitmap allocator for one slab of fixed-size slots: allocate and free.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. An allocate scans the used map one slot
// per cycle for the lowest free slot and loads the result register with its
// address; an allocate on a full slab loads it in the decode state. A free uses
// a restoring divider that turns the slab offset into a slot index one bit per
// cycle; a free outside the slab or with a zero slot size loads its result in
// the decode state. The result then moves through the emit state into the
// output register once it is free, and only then is the next request accepted;
// a finished result waits in the output register while that request is worked
// on. The used map is cleared at reset directly; there is no clearing pass.
// Configuration writes must only happen while the core is idle.
`default_nettype none

module slab_slot_allocator_core
  import ssa_pkg::*;
#(
  parameter int unsigned SLOTS = 64
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  // configuration write port
  input  wire                    cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire  [CFG_DATA_W-1:0]  cfg_data_i,
  // request stream
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire  [IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] slot_address
  input  wire                    s_axis_tuser,   // [0] operation
  // result stream
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [1:0] status, [33:2] granted_address,
                                                 // [40:34] free_count, [47:41] zero
);

  cmd_t cmd;
  sts_t sts;

  // request sequencing
  ssa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // slot map, arithmetic and result register
  ssa_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req_op_i    (s_axis_tuser),
    .req_addr_i  (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

/* rtl/ssa_checker.sv */
// ----------------------------------------------------------------------------
// Slab slot allocator checker
// Port-level properties of the allocator core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "slab_slot_allocator_core_defines.svh"

module ssa_checker
  import ssa_pkg::*;
#(
  parameter int unsigned SLOTS = 64
) (
  input wire                   clk_i,
  input wire                   rst_ni,
  input wire                   s_axis_tvalid,
  input wire                   s_axis_tready,
  input wire                   m_axis_tvalid,
  input wire                   m_axis_tready,
  input wire [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

  logic          in_beat;
  logic          out_beat;
  logic [1:0]    outst_q;
  logic [STATUS_W-1:0] res_status;
  logic [ADDR_W-1:0]   res_addr;
  logic [CNT_W-1:0]    res_cnt;

  assign in_beat    = s_axis_tvalid && s_axis_tready;
  assign out_beat   = m_axis_tvalid && m_axis_tready;
  assign res_status = m_axis_tdata[1:0];
  assign res_addr   = m_axis_tdata[33:2];
  assign res_cnt    = m_axis_tdata[40:34];

  // requests accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else if (in_beat && !out_beat) begin
      outst_q <= outst_q + 2'd1;
    end else if (!in_beat && out_beat) begin
      outst_q <= outst_q - 2'd1;
    end
  end

  // a stalled result holds
  `SSA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // every result answers an accepted request, at most two in flight
  `SSA_ASSERT_NOW(a_no_spurious, clk_i, rst_ni, out_beat, outst_q != 2'd0,
    "result without a request")
  `SSA_ASSERT_NOW(a_outst_bound, clk_i, rst_ni, 1'b1, outst_q <= 2'd2,
    "too many requests in flight")

  // free count within slab and full only with nothing free
  `SSA_ASSERT_NOW(a_full_result, clk_i, rst_ni,
    m_axis_tvalid && (res_status == ST_FULL),
    (res_cnt == '0) && (res_addr == '0), "full result with free slots or address")
  `SSA_ASSERT_NOW(a_cnt_range, clk_i, rst_ni, m_axis_tvalid, res_cnt <= SLOTS_CNT,
    "free count above slot count")

endmodule

bind slab_slot_allocator_core ssa_checker #(
  .SLOTS (SLOTS)
) u_ssa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
